>>> design/ialu_pkg.sv
// Package for the integer ALU with flags: opcodes, error codes, widths and queue entry type.
// No dependencies.
`timescale 1ns / 1ps
package ialu_pkg;
   localparam int WORD_BITS = 32;
   localparam int WIDE_BITS = 64;
   localparam int REG_INDEX_BITS_DEF = 4;
   localparam int CMD_BITS = 4;
   localparam int ERR_BITS = 2;

   typedef enum logic [3:0] {
      OP_STALL = 4'd0, OP_ADC = 4'd1, OP_SBC = 4'd2, OP_ADD = 4'd3, OP_SUB = 4'd4,
      OP_MUL = 4'd5, OP_DIV = 4'd6, OP_NAND = 4'd7, OP_AND = 4'd8, OP_OR = 4'd9,
      OP_XOR = 4'd10, OP_NOT = 4'd11, OP_SHL = 4'd12, OP_SAR = 4'd13, OP_MOD = 4'd14,
      OP_BAD = 4'd15
   } opcode_type;

   typedef enum logic [1:0] {
      ERR_NONE = 2'd0, ERR_DIV_ZERO = 2'd1, ERR_BAD_OP = 2'd2
   } err_type;

   // Operation class decided by the front end
   typedef enum logic [1:0] {
      CLS_SIMPLE = 2'd0, CLS_DIVIDE = 2'd1, CLS_HOLD = 2'd2
   } class_type;

   typedef enum logic [1:0] {
      BE_IDLE = 2'd0, BE_DIV = 2'd1, BE_FINISH = 2'd2
   } be_state_type;

   // Classified request passed from front to back
   typedef struct packed {
      class_type             cls;
      logic                  is_mod;
      logic [WIDE_BITS-1:0]  value;
      logic [WORD_BITS-1:0]  opa;
      logic [WORD_BITS-1:0]  opb;
      err_type               err;
      logic [7:0]            target;
   } task_type;
endpackage

>>> design/ialu_if.sv
// Valid/ready channel interface carrying a payload of parameterized type.
// Depends on nothing.
`timescale 1ns / 1ps
interface ialu_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> design/integer_alu_with_flags_core.sv
// Top level of the integer ALU with flags: front end, queue, back end.
// Depends on ialu_pkg, ialu_if, ialu_front, ialu_queue, ialu_back.
//
// Usage: requests come on req_ (valid/ready) with command, two signed 32-bit
// operands and a target register index. Each request gives exactly one
// response on rsp_ with the low 32 bits of the 64-bit result, echoed target,
// zero/carry/overflow flags and an error code. Stall, divide by zero and bad
// opcode keep the previously held result.
// Path: front register, queue, output register; divide and modulo also
// iterate in the back end's one-bit-per-cycle restoring divider, 32 steps
// plus finish, before the output register.
// Throughput: one request per cycle for simple operations while the
// receiver is ready; the back end takes nothing new while dividing.
// Reset clears the held result to zero and drops every queued request.
// When the receiver stalls, the output register holds, then the queue and
// the front register fill and req_ready falls.
`timescale 1ns / 1ps
module integer_alu_with_flags_core #(
   parameter int REG_INDEX_BITS = ialu_pkg::REG_INDEX_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [ialu_pkg::CMD_BITS-1:0]  req_command,
   input  logic signed [ialu_pkg::WORD_BITS-1:0] req_operand_a,
   input  logic signed [ialu_pkg::WORD_BITS-1:0] req_operand_b,
   input  logic [REG_INDEX_BITS-1:0]  req_target_reg,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [ialu_pkg::WORD_BITS-1:0] rsp_result_low,
   output logic [REG_INDEX_BITS-1:0]  rsp_target_out,
   output logic                        rsp_zero_flag,
   output logic                        rsp_carry_flag,
   output logic                        rsp_overflow_flag,
   output logic [ialu_pkg::ERR_BITS-1:0] rsp_error_code
);
   import ialu_pkg::*;

   ialu_if #(.payload_type(task_type)) f2q (.clock(clock));
   ialu_if #(.payload_type(task_type)) q2b (.clock(clock));

   ialu_front #(.REG_INDEX_BITS(REG_INDEX_BITS)) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_command(req_command),
      .req_operand_a(req_operand_a), .req_operand_b(req_operand_b),
      .req_target_reg(req_target_reg),
      .q_valid(f2q.valid), .q_ready(f2q.ready), .q_task(f2q.payload)
   );

   ialu_queue u_queue (
      .clock(clock), .reset(reset),
      .enq_valid(f2q.valid), .enq_ready(f2q.ready), .enq_task(f2q.payload),
      .deq_valid(q2b.valid), .deq_ready(q2b.ready), .deq_task(q2b.payload)
   );

   ialu_back #(.REG_INDEX_BITS(REG_INDEX_BITS)) u_back (
      .clock(clock), .reset(reset),
      .q_valid(q2b.valid), .q_ready(q2b.ready), .q_task(q2b.payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_result_low(rsp_result_low),
      .rsp_target_out(rsp_target_out), .rsp_zero_flag(rsp_zero_flag),
      .rsp_carry_flag(rsp_carry_flag), .rsp_overflow_flag(rsp_overflow_flag),
      .rsp_error_code(rsp_error_code)
   );
endmodule

>>> design/ialu_front.sv
// Front end: accepts requests, classifies them and computes the simple operations' results.
// Depends on ialu_pkg.
`timescale 1ns / 1ps
module ialu_front #(
   parameter int REG_INDEX_BITS = ialu_pkg::REG_INDEX_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [ialu_pkg::CMD_BITS-1:0]  req_command,
   input  logic signed [ialu_pkg::WORD_BITS-1:0] req_operand_a,
   input  logic signed [ialu_pkg::WORD_BITS-1:0] req_operand_b,
   input  logic [REG_INDEX_BITS-1:0]  req_target_reg,
   output logic                        q_valid,
   input  logic                        q_ready,
   output ialu_pkg::task_type          q_task
);
   import ialu_pkg::*;

   logic                        valid_ff, valid_in;
   task_type                    task_ff, task_in;
   logic [WIDE_BITS-1:0]        ua, ub;
   logic signed [WIDE_BITS-1:0] prod;
   logic [5:0]                  sh;
   opcode_type                  op;

   assign req_ready = !valid_ff || q_ready;
   assign q_valid   = valid_ff;
   assign q_task    = task_ff;

   // Classify and compute the short operations
   always_comb begin
      ua = {{WORD_BITS{req_operand_a[WORD_BITS-1]}}, req_operand_a};
      ub = {{WORD_BITS{req_operand_b[WORD_BITS-1]}}, req_operand_b};
      sh = req_operand_b[5:0];
      op = opcode_type'(req_command);
      // signed 32x32 product, full 64 bits
      prod = WIDE_BITS'(req_operand_a) * WIDE_BITS'(req_operand_b);
      task_in = '0;
      task_in.opa = req_operand_a;
      task_in.opb = req_operand_b;
      task_in.target = 8'(req_target_reg);
      task_in.cls = CLS_SIMPLE;
      task_in.err = ERR_NONE;
      case (op)
         OP_STALL: task_in.cls = CLS_HOLD;
         OP_ADC, OP_ADD: task_in.value = ua + ub;
         OP_SBC, OP_SUB: task_in.value = ua - ub;
         OP_MUL: task_in.value = prod;
         OP_DIV, OP_MOD: begin
            task_in.is_mod = (op == OP_MOD);
            if (req_operand_b == '0) begin
               task_in.cls = CLS_HOLD;
               task_in.err = ERR_DIV_ZERO;
            end else begin
               task_in.cls = CLS_DIVIDE;
            end
         end
         OP_NAND: task_in.value = ~(ua & ub);
         OP_AND: task_in.value = ua & ub;
         OP_OR: task_in.value = ua | ub;
         OP_XOR: task_in.value = ua ^ ub;
         OP_NOT: task_in.value = ~ua;
         OP_SHL: task_in.value = ua << sh;
         OP_SAR: task_in.value = $signed(ua) >>> sh;
         default: begin
            task_in.cls = CLS_HOLD;
            task_in.err = ERR_BAD_OP;
         end
      endcase
   end

   // Hold or advance the output stage
   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) valid_in = 1'b1;
      else if (q_ready) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      if (req_valid && req_ready) task_ff <= task_in;
   end
endmodule

>>> design/ialu_queue.sv
// Two-entry queue between front and back end.
// Depends on ialu_pkg.
`timescale 1ns / 1ps
module ialu_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               enq_valid,
   output logic               enq_ready,
   input  ialu_pkg::task_type enq_task,
   output logic               deq_valid,
   input  logic               deq_ready,
   output ialu_pkg::task_type deq_task
);
   import ialu_pkg::*;

   task_type   mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign enq_ready = (cnt_ff != 2'd2);
   assign deq_valid = (cnt_ff != 2'd0);
   assign deq_task  = mem_ff[rp_ff];
   assign push = enq_valid && enq_ready;
   assign pop  = deq_valid && deq_ready;

   // Advance pointers and count
   always_comb begin
      wp_in  = push ? !wp_ff : wp_ff;
      rp_in  = pop ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= enq_task;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue count out of range");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !push) else $error("push into full queue");
   a_pop_dec: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> cnt_ff == $past(cnt_ff) - 2'd1) else $error("pop count slip");
endmodule

>>> design/ialu_back.sv
// Back end: radix-2 divider, held result register, flags and output register.
// Depends on ialu_pkg.
`timescale 1ns / 1ps
module ialu_back #(
   parameter int REG_INDEX_BITS = ialu_pkg::REG_INDEX_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   output logic                        q_ready,
   input  ialu_pkg::task_type          q_task,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [ialu_pkg::WORD_BITS-1:0] rsp_result_low,
   output logic [REG_INDEX_BITS-1:0]  rsp_target_out,
   output logic                        rsp_zero_flag,
   output logic                        rsp_carry_flag,
   output logic                        rsp_overflow_flag,
   output logic [ialu_pkg::ERR_BITS-1:0] rsp_error_code
);
   import ialu_pkg::*;

   be_state_type          state_ff, state_in;
   logic [WIDE_BITS-1:0]  held_ff, held_in, mag, r;
   logic [WORD_BITS-1:0]  quo_ff, quo_in, rem_ff, rem_in, dvs_ff, dvs_in;
   logic [5:0]            cnt_ff, cnt_in;
   logic                  neg_q_ff, neg_q_in, neg_r_ff, neg_r_in, mod_ff, mod_in;
   logic [WORD_BITS:0]    trial;
   logic [WORD_BITS-1:0]  absa, absb, qs, rs;
   logic                  ovalid_ff, ovalid_in, load_out;
   logic [WORD_BITS-1:0]  olow_ff;
   logic [REG_INDEX_BITS-1:0] otgt_ff, tgt_ff, tgt_in;
   logic                  oz_ff, oc_ff, oo_ff;
   err_type               oerr_ff, err_sel;

   assign rsp_valid = ovalid_ff;
   assign rsp_result_low = olow_ff;
   assign rsp_target_out = otgt_ff;
   assign rsp_zero_flag = oz_ff;
   assign rsp_carry_flag = oc_ff;
   assign rsp_overflow_flag = oo_ff;
   assign rsp_error_code = oerr_ff;

   // Sequence the back end: simple ops finish at once, divides iterate
   always_comb begin
      absa = q_task.opa[WORD_BITS-1] ? -q_task.opa : q_task.opa;
      absb = q_task.opb[WORD_BITS-1] ? -q_task.opb : q_task.opb;
      trial = {rem_ff, quo_ff[WORD_BITS-1]} - {1'b0, dvs_ff};
      qs = neg_q_ff ? -quo_ff : quo_ff;
      rs = neg_r_ff ? -rem_ff : rem_ff;
      state_in = state_ff;
      held_in = held_ff;
      quo_in = quo_ff; rem_in = rem_ff; dvs_in = dvs_ff; cnt_in = cnt_ff;
      neg_q_in = neg_q_ff; neg_r_in = neg_r_ff; mod_in = mod_ff; tgt_in = tgt_ff;
      q_ready = 1'b0;
      load_out = 1'b0;
      err_sel = ERR_NONE;
      r = held_ff;
      case (state_ff)
         BE_IDLE: begin
            q_ready = !ovalid_ff || rsp_ready;
            if (q_valid && q_ready) begin
               if (q_task.cls == CLS_DIVIDE) begin
                  state_in = BE_DIV;
                  quo_in = absa; rem_in = '0; dvs_in = absb; cnt_in = 6'd0;
                  neg_q_in = q_task.opa[WORD_BITS-1] ^ q_task.opb[WORD_BITS-1];
                  neg_r_in = q_task.opa[WORD_BITS-1];
                  mod_in = q_task.is_mod;
                  tgt_in = q_task.target[REG_INDEX_BITS-1:0];
               end else begin
                  load_out = 1'b1;
                  err_sel = q_task.err;
                  if (q_task.cls == CLS_SIMPLE) r = q_task.value;
                  held_in = r;
               end
            end
         end
         BE_DIV: begin
            // one restoring step per cycle
            if (!trial[WORD_BITS]) begin
               rem_in = trial[WORD_BITS-1:0];
               quo_in = {quo_ff[WORD_BITS-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[WORD_BITS-2:0], quo_ff[WORD_BITS-1]};
               quo_in = {quo_ff[WORD_BITS-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(WORD_BITS - 1)) state_in = BE_FINISH;
         end
         BE_FINISH: begin
            if (!ovalid_ff || rsp_ready) begin
               load_out = 1'b1;
               // quotient 2^31 (min / -1) stays positive in 64 bits
               r = mod_ff ? {{WORD_BITS{rs[WORD_BITS-1]}}, rs}
                          : (neg_q_ff ? {{WORD_BITS{qs[WORD_BITS-1]}}, qs}
                                      : {{WORD_BITS{1'b0}}, quo_ff});
               held_in = r;
               state_in = BE_IDLE;
            end
         end
         default: state_in = BE_IDLE;
      endcase
      mag = r[WIDE_BITS-1] ? -r : r;
      ovalid_in = load_out ? 1'b1 : (rsp_ready ? 1'b0 : ovalid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BE_IDLE;
         held_ff <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         held_ff <= held_in;
         ovalid_ff <= ovalid_in;
      end
      quo_ff <= quo_in; rem_ff <= rem_in; dvs_ff <= dvs_in; cnt_ff <= cnt_in;
      neg_q_ff <= neg_q_in; neg_r_ff <= neg_r_in; mod_ff <= mod_in; tgt_ff <= tgt_in;
      if (load_out) begin
         olow_ff <= r[WORD_BITS-1:0];
         otgt_ff <= (state_ff == BE_FINISH) ? tgt_ff : q_task.target[REG_INDEX_BITS-1:0];
         oz_ff <= (r == '0);
         oc_ff <= mag[WORD_BITS];
         oo_ff <= (mag > (WIDE_BITS'(1) << WORD_BITS));
         oerr_ff <= err_sel;
      end
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ovalid_ff && !rsp_ready |-> !load_out) else $error("result overwritten");
   a_div_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == BE_DIV && cnt_ff == 6'd0 |-> $past(state_ff) == BE_IDLE)
      else $error("divider started mid-run");
   a_idle_only_take: assert property (@(posedge clock) disable iff (reset)
      q_ready |-> state_ff == BE_IDLE) else $error("take outside idle");
endmodule
